@@ hdl/iant_pkg.sv @@
// shared types and character constants for the identifier and number tokenizer
`default_nettype none
package iant_pkg;

    typedef enum logic [2:0] {
        KIND_IDENT = 3'd0,
        KIND_DEC   = 3'd1,
        KIND_OCT   = 3'd2,
        KIND_HEX   = 3'd3,
        KIND_CHAR  = 3'd4,
        KIND_END   = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDENT = 3'd1,
        MODE_DEC   = 3'd2,
        MODE_ZERO  = 3'd3,
        MODE_OCT   = 3'd4,
        MODE_ZEROX = 3'd5,
        MODE_HEX   = 3'd6
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_value;
        logic [7:0] length;
    } t_result;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] LEN_MAX   = 8'hFF;

endpackage
`default_nettype wire

@@ hdl/identifier_and_number_tokenizer.sv @@
// streaming lexer for identifiers and integer literals, one byte per transaction
//
// input channel: i_valid / o_stall carry one byte (i_byte_in) or an end mark
// (i_end_of_input high, byte ignored). output channel: o_valid / i_stall carry
// one token per transaction: kind, char value, length and last_of_run, which
// is high on the final token caused by one input transaction.
// each accepted input is decoded in the same cycle against the scan mode and
// pending length registers; the 0..3 tokens it produces are loaded into a
// three-entry result queue and appear on the output from the next cycle on.
// throughput is one byte per cycle while each byte yields at most one token
// and i_stall is low; a byte that yields two or three tokens holds o_stall
// while the queue drains, one token per cycle while i_stall is low. input
// is taken when the queue is empty or its last token leaves in the same cycle.
// a stalled output holds its token. a number or identifier token is emitted
// only once a later byte or end mark ends it; every end mark yields an end token.
// reset: scan mode idle, pending length zero, queue empty.
`default_nettype none
module identifier_and_number_tokenizer (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  [7:0]            i_byte_in,
    input  wire                   i_end_of_input,
    output logic                  o_valid,
    input  wire                   i_stall,
    output iant_pkg::t_kind       o_token_kind,
    output logic [7:0]            o_char_value,
    output logic [7:0]            o_token_length,
    output logic                  o_last_of_run
);
    import iant_pkg::*;

    // scanner state
    t_mode      r_mode, n_mode;
    logic [7:0] r_len,  n_len;

    // result queue, loaded whole on each accepted input
    t_result    r_q [3];
    logic [1:0] r_head;
    logic [1:0] r_cnt;

    // tokens produced by the current input
    t_result    e_res [3];
    logic [1:0] e_n;
    logic       idle_stage;

    logic in_acc, out_acc;

    // character classes of the incoming byte
    logic c_space, c_alpha, c_digit, c_octal, c_hex, c_x, c_alnum;
    logic [7:0] len_bump;

    assign c_space = (i_byte_in == CH_SPACE) ||
                     (i_byte_in >= CH_TAB && i_byte_in <= CH_CR);
    assign c_alpha = (i_byte_in >= 8'h41 && i_byte_in <= 8'h5A) ||
                     (i_byte_in >= 8'h61 && i_byte_in <= 8'h7A);
    assign c_digit = (i_byte_in >= CH_ZERO && i_byte_in <= CH_NINE);
    assign c_octal = (i_byte_in >= CH_ZERO && i_byte_in <= CH_SEVEN);
    assign c_hex   = c_digit || (i_byte_in >= 8'h41 && i_byte_in <= 8'h46) ||
                     (i_byte_in >= 8'h61 && i_byte_in <= 8'h66);
    assign c_x     = (i_byte_in == CH_LOW_X) || (i_byte_in == CH_UP_X);
    assign c_alnum = c_alpha || c_digit;

    // saturating length increment
    assign len_bump = (r_len == LEN_MAX) ? LEN_MAX : 8'(r_len + 8'd1);

    // handshake: take a new byte only when the queue is empty or empties this cycle
    assign o_valid = (r_cnt != 2'd0);
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_cnt > 2'd1) || ((r_cnt == 2'd1) && i_stall);
    assign in_acc  = i_valid && !o_stall;

    assign o_token_kind   = r_q[r_head].kind;
    assign o_char_value   = r_q[r_head].char_value;
    assign o_token_length = r_q[r_head].length;
    assign o_last_of_run  = (r_cnt == 2'd1);

    // next scanner state and emitted tokens
    always_comb begin
        e_res      = '{default: '0};
        e_n        = 2'd0;
        n_mode     = r_mode;
        n_len      = r_len;
        idle_stage = 1'b0;

        if (i_end_of_input) begin
            // flush the pending token, then the end token
            case (r_mode)
                MODE_IDENT: begin
                    e_res[e_n] = '{KIND_IDENT, 8'd0, r_len};
                    e_n = e_n + 2'd1;
                end
                MODE_DEC: begin
                    e_res[e_n] = '{KIND_DEC, 8'd0, r_len};
                    e_n = e_n + 2'd1;
                end
                MODE_ZERO: begin
                    e_res[e_n] = '{KIND_DEC, 8'd0, 8'd1};
                    e_n = e_n + 2'd1;
                end
                MODE_OCT: begin
                    e_res[e_n] = '{KIND_OCT, 8'd0, r_len};
                    e_n = e_n + 2'd1;
                end
                MODE_ZEROX: begin
                    // "0x" falls back to decimal zero then identifier x
                    e_res[e_n] = '{KIND_DEC, 8'd0, 8'd1};
                    e_n = e_n + 2'd1;
                    e_res[e_n] = '{KIND_IDENT, 8'd0, 8'd1};
                    e_n = e_n + 2'd1;
                end
                MODE_HEX: begin
                    e_res[e_n] = '{KIND_HEX, 8'd0, r_len};
                    e_n = e_n + 2'd1;
                end
                default: begin
                end
            endcase
            e_res[e_n] = '{KIND_END, 8'd0, 8'd0};
            e_n = e_n + 2'd1;
            n_mode = MODE_IDLE;
            n_len  = 8'd0;
        end else begin
            // pending token: extend it or close it
            unique case (r_mode)
                MODE_IDENT: begin
                    if (c_alnum) begin
                        n_len = len_bump;
                    end else begin
                        e_res[e_n] = '{KIND_IDENT, 8'd0, r_len};
                        e_n = e_n + 2'd1;
                        idle_stage = 1'b1;
                    end
                end
                MODE_DEC: begin
                    if (c_digit) begin
                        n_len = len_bump;
                    end else begin
                        e_res[e_n] = '{KIND_DEC, 8'd0, r_len};
                        e_n = e_n + 2'd1;
                        idle_stage = 1'b1;
                    end
                end
                MODE_ZERO: begin
                    if (c_octal) begin
                        n_mode = MODE_OCT;
                        n_len  = 8'd2;
                    end else if (c_x) begin
                        n_mode = MODE_ZEROX;
                        n_len  = 8'd2;
                    end else begin
                        e_res[e_n] = '{KIND_DEC, 8'd0, 8'd1};
                        e_n = e_n + 2'd1;
                        idle_stage = 1'b1;
                    end
                end
                MODE_OCT: begin
                    if (c_octal) begin
                        n_len = len_bump;
                    end else begin
                        e_res[e_n] = '{KIND_OCT, 8'd0, r_len};
                        e_n = e_n + 2'd1;
                        idle_stage = 1'b1;
                    end
                end
                MODE_ZEROX: begin
                    if (c_hex) begin
                        n_mode = MODE_HEX;
                        n_len  = 8'd3;
                    end else begin
                        // no hex digit: decimal zero, x opens an identifier
                        e_res[e_n] = '{KIND_DEC, 8'd0, 8'd1};
                        e_n = e_n + 2'd1;
                        if (c_alnum) begin
                            n_mode = MODE_IDENT;
                            n_len  = 8'd2;
                        end else begin
                            e_res[e_n] = '{KIND_IDENT, 8'd0, 8'd1};
                            e_n = e_n + 2'd1;
                            idle_stage = 1'b1;
                        end
                    end
                end
                MODE_HEX: begin
                    if (c_hex) begin
                        n_len = len_bump;
                    end else begin
                        e_res[e_n] = '{KIND_HEX, 8'd0, r_len};
                        e_n = e_n + 2'd1;
                        idle_stage = 1'b1;
                    end
                end
                default: begin
                    // idle, and the unused code
                    idle_stage = 1'b1;
                end
            endcase

            // byte starts a new token from idle
            if (idle_stage) begin
                n_len = 8'd1;
                if (c_space) begin
                    n_mode = MODE_IDLE;
                    n_len  = 8'd0;
                end else if (c_alpha) begin
                    n_mode = MODE_IDENT;
                end else if (i_byte_in == CH_ZERO) begin
                    n_mode = MODE_ZERO;
                end else if (c_digit) begin
                    n_mode = MODE_DEC;
                end else begin
                    e_res[e_n] = '{KIND_CHAR, i_byte_in, 8'd1};
                    e_n = e_n + 2'd1;
                    n_mode = MODE_IDLE;
                    n_len  = 8'd0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_len  <= 8'd0;
            r_head <= 2'd0;
            r_cnt  <= 2'd0;
        end else if (in_acc) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_head <= 2'd0;
            r_cnt  <= e_n;
        end else if (out_acc) begin
            r_head <= r_head + 2'd1;
            r_cnt  <= r_cnt - 2'd1;
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_q <= e_res;
        end
    end

endmodule
`default_nettype wire

@@ hdl/iant_checker.sv @@
// port-level checks for the tokenizer and their bind to the top level
`default_nettype none
module iant_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_valid,
    input wire                  o_stall,
    input wire [7:0]            i_byte_in,
    input wire                  i_end_of_input,
    input wire                  o_valid,
    input wire                  i_stall,
    input iant_pkg::t_kind      o_token_kind,
    input wire [7:0]            o_char_value,
    input wire [7:0]            o_token_length,
    input wire                  o_last_of_run
);
    import iant_pkg::*;

    // a stalled input transaction holds until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_byte_in) &&
            $stable(i_end_of_input))
        else $error("stalled input transaction changed");

    // a stalled token holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind) &&
            $stable(o_char_value) && $stable(o_token_length) &&
            $stable(o_last_of_run))
        else $error("stalled token changed");

    // the end token always closes its run and has no length
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_END |-> o_last_of_run &&
            o_token_length == 8'd0)
        else $error("end token malformed");

    // single-character tokens have length one
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_CHAR |-> o_token_length == 8'd1)
        else $error("single-character token length wrong");

    // only single-character tokens carry a char value
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind != KIND_CHAR |-> o_char_value == 8'd0)
        else $error("char value on a multi-character token");

endmodule

bind identifier_and_number_tokenizer iant_checker u_iant_checker (.*);
`default_nettype wire

@@ verif/tb_identifier_and_number_tokenizer.sv @@
// self-checking testbench for the identifier and integer literal tokenizer
`timescale 1ns / 100ps
`default_nettype none
module tb_identifier_and_number_tokenizer;
    import iant_pkg::*;

    // token predictor and in-order checker: mirrors the scan mode and the
    // pending length, queues the tokens each input transaction must produce
    class token_checker;
        t_mode      scan_st;
        logic [7:0] pend_len;
        t_result    run_tokens[$];
        t_result    pending_tokens[$];
        bit         pending_last[$];
        int         n_checked;
        int         n_errors;
        int         n_saturated;
        int         n_end_tokens;

        function new();
            scan_st      = MODE_IDLE;
            pend_len     = 8'd0;
            n_checked    = 0;
            n_errors     = 0;
            n_saturated  = 0;
            n_end_tokens = 0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_octal(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_SEVEN;
        endfunction

        function bit is_hexdig(logic [7:0] c);
            return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function void push_token(t_kind k, logic [7:0] ch, logic [7:0] len);
            t_result r;
            r.kind       = k;
            r.char_value = ch;
            r.length     = len;
            if (run_tokens.size() < 3)
                run_tokens.push_back(r);
        endfunction

        function void restart(t_mode m, logic [7:0] len);
            scan_st  = m;
            pend_len = len;
        endfunction

        function void grow();
            if (pend_len != LEN_MAX)
                pend_len = pend_len + 8'd1;
        endfunction

        // one byte may close the pending token and then be rescanned from idle
        function void scan_byte(logic [7:0] c);
            for (int pass = 0; pass < 4; pass++) begin
                case (scan_st)
                    MODE_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            grow();
                            return;
                        end
                        push_token(KIND_IDENT, 8'h00, pend_len);
                        restart(MODE_IDLE, 8'd0);
                    end
                    MODE_DEC: begin
                        if (is_digit(c)) begin
                            grow();
                            return;
                        end
                        push_token(KIND_DEC, 8'h00, pend_len);
                        restart(MODE_IDLE, 8'd0);
                    end
                    MODE_ZERO: begin
                        if (is_octal(c)) begin
                            restart(MODE_OCT, 8'd2);
                            return;
                        end
                        if (c == CH_LOW_X || c == CH_UP_X) begin
                            restart(MODE_ZEROX, 8'd2);
                            return;
                        end
                        push_token(KIND_DEC, 8'h00, 8'd1);
                        restart(MODE_IDLE, 8'd0);
                    end
                    MODE_OCT: begin
                        if (is_octal(c)) begin
                            grow();
                            return;
                        end
                        push_token(KIND_OCT, 8'h00, pend_len);
                        restart(MODE_IDLE, 8'd0);
                    end
                    MODE_ZEROX: begin
                        if (is_hexdig(c)) begin
                            restart(MODE_HEX, 8'd3);
                            return;
                        end
                        // zero then an identifier x that this byte may extend
                        push_token(KIND_DEC, 8'h00, 8'd1);
                        restart(MODE_IDENT, 8'd1);
                    end
                    MODE_HEX: begin
                        if (is_hexdig(c)) begin
                            grow();
                            return;
                        end
                        push_token(KIND_HEX, 8'h00, pend_len);
                        restart(MODE_IDLE, 8'd0);
                    end
                    default: begin
                        if (is_space(c))
                            restart(MODE_IDLE, 8'd0);
                        else if (is_alpha(c))
                            restart(MODE_IDENT, 8'd1);
                        else if (c == CH_ZERO)
                            restart(MODE_ZERO, 8'd1);
                        else if (is_digit(c))
                            restart(MODE_DEC, 8'd1);
                        else begin
                            push_token(KIND_CHAR, c, 8'd1);
                            restart(MODE_IDLE, 8'd0);
                        end
                        return;
                    end
                endcase
            end
        endfunction

        function void flush_pending();
            case (scan_st)
                MODE_IDENT: push_token(KIND_IDENT, 8'h00, pend_len);
                MODE_DEC:   push_token(KIND_DEC, 8'h00, pend_len);
                MODE_ZERO:  push_token(KIND_DEC, 8'h00, 8'd1);
                MODE_OCT:   push_token(KIND_OCT, 8'h00, pend_len);
                MODE_ZEROX: begin
                    push_token(KIND_DEC, 8'h00, 8'd1);
                    push_token(KIND_IDENT, 8'h00, 8'd1);
                end
                MODE_HEX:   push_token(KIND_HEX, 8'h00, pend_len);
                default: ;
            endcase
            push_token(KIND_END, 8'h00, 8'd0);
            restart(MODE_IDLE, 8'd0);
        endfunction

        function void take_char(logic [7:0] c, logic end_mark);
            run_tokens.delete();
            if (end_mark)
                flush_pending();
            else
                scan_byte(c);
            foreach (run_tokens[i]) begin
                pending_tokens.push_back(run_tokens[i]);
                pending_last.push_back(i == run_tokens.size() - 1);
            end
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function void check_token(t_kind k, logic [7:0] ch, logic [7:0] len, logic last);
            t_result want;
            bit      want_last;
            if (pending_tokens.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected token: kind %0d char %02h len %0d last %0b",
                             k, ch, len, last);
                return;
            end
            want      = pending_tokens.pop_front();
            want_last = pending_last.pop_front();
            n_checked++;
            if (want.kind == KIND_END)
                n_end_tokens++;
            if (want.length == LEN_MAX)
                n_saturated++;
            if (k !== want.kind || ch !== want.char_value || len !== want.length ||
                last !== want_last) begin
                n_errors++;
                if (n_errors <= 10)
                    $display({"token %0d mismatch: exp kind %0d char %02h len %0d ",
                              "last %0b, got kind %0d char %02h len %0d last %0b"},
                             n_checked, want.kind, want.char_value, want.length,
                             want_last, k, ch, len, last);
            end
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_valid        = 1'b0;
    logic [7:0] i_byte_in      = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       i_stall        = 1'b0;
    logic       o_stall;
    logic       o_valid;
    t_kind      o_token_kind;
    logic [7:0] o_char_value;
    logic [7:0] o_token_length;
    logic       o_last_of_run;

    token_checker chk = new();

    // sender burst state
    int unsigned burst_left = 0;
    int unsigned n_sent     = 0;

    // receiver stall pattern state
    int unsigned stall_style = 0;
    int unsigned stall_hold  = 0;
    int unsigned stall_tick  = 0;

    string punct = "+-*/;,(){}[]=<>!&|^~%#?.:@$";

    identifier_and_number_tokenizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_in      (i_byte_in),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_char_value   (o_char_value),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // both channels are sampled at the rising edge; inputs only move on the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                chk.take_char(i_byte_in, i_end_of_input);
            if (o_valid && !i_stall)
                chk.check_token(o_token_kind, o_char_value, o_token_length, o_last_of_run);
        end
    end

    // receiver backpressure in one of four randomly chosen styles:
    // none, periodic, light random or heavy random
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_hold == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_hold  <= $urandom_range(20, 80);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_style)
            0:       i_stall <= 1'b0;
            1:       i_stall <= (stall_tick % 4 == 3);
            2:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 4) < 3);
        endcase
    end

    function automatic logic [7:0] rand_alpha();
        return 8'(($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return ($urandom_range(0, 3) == 0) ? 8'(CH_ZERO + $urandom_range(0, 9)) :
                                             rand_alpha();
    endfunction

    function automatic logic [7:0] rand_hexdig();
        case ($urandom_range(0, 2))
            0:       return 8'(CH_ZERO + $urandom_range(0, 9));
            1:       return 8'("a" + $urandom_range(0, 5));
            default: return 8'("A" + $urandom_range(0, 5));
        endcase
    endfunction

    // one input transaction; called on a falling edge, returns on a falling edge
    // the sender works in bursts with random gaps in between
    task automatic send_char(input logic [7:0] c, input logic end_mark);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_byte_in      <= c;
        i_end_of_input <= end_mark;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // hold the sender until every predicted token has come out
    task automatic drain_outputs();
        i_valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // one randomly shaped piece of source text; mostly well-formed lexemes
    // placed back to back, with separators, noise, broken prefixes and end marks
    task automatic send_random_piece();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            send_char(rand_alpha(), 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send_char(rand_alnum(), 1'b0);
        end else if (pick < 30) begin
            send_char(8'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
            n = $urandom_range(0, 5);
            repeat (n) send_char(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
        end else if (pick < 44) begin
            // octal, sometimes running into an 8 or 9
            send_char(CH_ZERO, 1'b0);
            n = $urandom_range(1, 5);
            repeat (n) send_char(8'(CH_ZERO + $urandom_range(0, 7)), 1'b0);
            if (pick >= 40)
                send_char(8'(CH_ZERO + $urandom_range(8, 9)), 1'b0);
        end else if (pick < 56) begin
            send_char(CH_ZERO, 1'b0);
            send_char($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X, 1'b0);
            n = $urandom_range(1, 5);
            repeat (n) send_char(rand_hexdig(), 1'b0);
        end else if (pick < 60) begin
            send_char(CH_ZERO, 1'b0);
        end else if (pick < 65) begin
            // zero-x with no hex digit behind it
            send_char(CH_ZERO, 1'b0);
            send_char($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X, 1'b0);
        end else if (pick < 80) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 1))
                    send_char(CH_SPACE, 1'b0);
                else
                    send_char(8'(CH_TAB + $urandom_range(0, 4)), 1'b0);
            end
        end else if (pick < 90) begin
            send_char(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
        end else if (pick < 97) begin
            send_char(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_char(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int unsigned random_base;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: end mark while idle
        send_char(8'h5A, 1'b1);
        // identifier closed by whitespace
        send_text("aZ9 ");
        // octal cut by an 8, then a decimal closed by a tab
        send_text("078\t");
        // zero-x with no hex digit, x grows into an identifier, punctuation ends it
        send_text("0xg+");
        // upper-case hex closed by a high byte
        send_text("0XFa");
        send_char(8'hFF, 1'b0);
        // lone zero followed by punctuation
        send_text("0;");
        // zero, identifier x and a character token from a single byte
        send_text("0x+");
        // end mark right after zero-x: zero, x and end token
        send_text("0x");
        send_char(8'hA5, 1'b1);
        // octal flushed by end of input, the byte beside the mark is ignored
        send_text("07");
        send_char(8'h80, 1'b1);
        // decimal then carriage return, and a null byte as a character token
        send_text("5\r");
        send_char(8'h00, 1'b0);
        send_char(8'h00, 1'b1);
        drain_outputs();

        // random source text
        random_base = n_sent;
        while (n_sent < random_base + 60)
            send_random_piece();
        drain_outputs();
        while (n_sent < random_base + 125)
            send_random_piece();
        send_char(8'h00, 1'b1);

        // wait for the tail of the output stream
        i_valid <= 1'b0;
        while (chk.pending() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("sent %0d input transactions, compared %0d tokens (%0d end tokens)",
                 n_sent, chk.n_checked, chk.n_end_tokens);
        $display("%0d tokens at saturated length, %0d mismatches",
                 chk.n_saturated, chk.n_errors);
        if (chk.n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
